FILE: hdl/kwm_pkg.sv
// Shared constants and codes for the k-way sorted merge block.
`default_nettype none

package kwm_pkg;

  // Default sizes
  localparam int KWM_NUM_LISTS  = 8;
  localparam int KWM_LIST_DEPTH = 64;
  localparam int KWM_DATA_WIDTH = 16;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FULL  = 3'd2,
    ST_ORDER = 3'd3,
    ST_BAD   = 3'd4
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/kwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module kwm_ram #(
  parameter  int WIDTH  = 8,
  parameter  int DEPTH  = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hdl/k_way_sorted_merge_top.sv
// Top level of the k-way sorted merge: per-list FIFO banks in RAM, serial min scan on pop.
// Throughput: one item at a time; the next beat is taken the cycle after the result is loaded.
// The pop's meta scan reads one list per cycle.
// Reset (rst_n, synchronous): empties all lists via per-list live bits, lists_in_use = NUM_LISTS;
// the RAMs are not swept, so there is no clearing pass.
`default_nettype none

module k_way_sorted_merge_top
  import kwm_pkg::*;
#(
  parameter  int NUM_LISTS  = KWM_NUM_LISTS,
  parameter  int LIST_DEPTH = KWM_LIST_DEPTH,
  parameter  int DATA_WIDTH = KWM_DATA_WIDTH,
  localparam int SEL_W      = $clog2(NUM_LISTS),
  localparam int CFG_W      = $clog2(NUM_LISTS + 1),
  localparam int IN_W       = ((SEL_W + DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_W      = ((DATA_WIDTH + SEL_W + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,

  // lists_in_use register write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data,

  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IN_W-1:0]     in_tdata,   // list_select, push_value, zero pad
  input  logic [CMD_W-1:0]    in_tuser,   // command

  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_W-1:0]    out_tdata,  // out_value, source_list, zero pad
  output logic [STATUS_W-1:0] out_tuser   // status
);

  localparam int PTR_W       = $clog2(LIST_DEPTH);
  localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
  localparam int STORE_DEPTH = NUM_LISTS << PTR_W;

  // Per-list metadata word held in the metadata RAM
  typedef struct packed {
    logic [PTR_W-1:0]      rp;
    logic [CNT_W-1:0]      cnt;
    logic [DATA_WIDTH-1:0] tail;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PUSH = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] cfg_r;
  logic [CFG_W-1:0] n_act;

  // A list whose live bit is clear reads as empty, whatever its RAM word holds
  logic [NUM_LISTS-1:0] live_r, live_nxt;

  logic [SEL_W-1:0]      sel_r, sel_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;

  // Scan pipeline: issue -> meta read (s1) -> head read (s2) -> compare
  logic [CFG_W-1:0] iss_r, iss_nxt;
  logic             s1_v_r, s1_v_nxt;
  logic [SEL_W-1:0] s1_idx_r, s1_idx_nxt;
  logic             s2_v_r, s2_v_nxt;
  logic [SEL_W-1:0] s2_idx_r, s2_idx_nxt;
  meta_t            s2_meta_r, s2_meta_nxt;

  logic                         found_r, found_nxt;
  logic [SEL_W-1:0]             best_idx_r, best_idx_nxt;
  logic signed [DATA_WIDTH-1:0] best_val_r, best_val_nxt;
  meta_t                        best_meta_r, best_meta_nxt;

  logic [DATA_WIDTH-1:0] res_val_r, res_val_nxt;
  logic [SEL_W-1:0]      res_src_r, res_src_nxt;
  status_t               res_st_r, res_st_nxt;

  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_val_r;
  logic [SEL_W-1:0]      out_src_r;
  status_t               out_st_r;
  logic                  out_load;

  // RAM ports
  logic                          meta_we;
  logic [SEL_W-1:0]              meta_waddr;
  meta_t                         meta_wdata;
  logic [SEL_W-1:0]              meta_raddr;
  logic [META_W-1:0]             meta_rdata;
  logic                          store_we;
  logic [SEL_W+PTR_W-1:0]        store_waddr;
  logic [DATA_WIDTH-1:0]         store_wdata;
  logic [SEL_W+PTR_W-1:0]        store_raddr;
  logic [DATA_WIDTH-1:0]         store_rdata;

  logic                  in_fire;
  cmd_t                  in_cmd;
  logic [SEL_W-1:0]      in_sel;
  logic [DATA_WIDTH-1:0] in_val;

  meta_t            push_meta;
  meta_t            scan_meta;
  logic [PTR_W:0]   pos_sum;
  logic [PTR_W-1:0] push_pos;
  logic [PTR_W-1:0] rp_inc;
  logic             push_full;
  logic             push_order;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_cmd    = cmd_t'(in_tuser);
  assign in_sel    = in_tdata[SEL_W-1:0];
  assign in_val    = in_tdata[SEL_W +: DATA_WIDTH];

  // Out-of-range register values clamp to 1..NUM_LISTS
  always_comb begin
    if (cfg_r == '0) begin
      n_act = CFG_W'(1);
    end else if (cfg_r > CFG_W'(NUM_LISTS)) begin
      n_act = CFG_W'(NUM_LISTS);
    end else begin
      n_act = cfg_r;
    end
  end

  assign push_meta = live_r[sel_r]    ? meta_t'(meta_rdata) : '0;
  assign scan_meta = live_r[s1_idx_r] ? meta_t'(meta_rdata) : '0;

  // Tail slot: rp + cnt wraps at most once
  assign pos_sum  = (PTR_W+1)'(push_meta.rp) + (PTR_W+1)'(push_meta.cnt);
  assign push_pos = (pos_sum >= (PTR_W+1)'(LIST_DEPTH)) ?
                    PTR_W'(pos_sum - (PTR_W+1)'(LIST_DEPTH)) : PTR_W'(pos_sum);
  assign rp_inc   = (best_meta_r.rp == PTR_W'(LIST_DEPTH - 1)) ?
                    '0 : best_meta_r.rp + PTR_W'(1);

  assign push_full  = (push_meta.cnt == CNT_W'(LIST_DEPTH));
  assign push_order = (push_meta.cnt != '0) &&
                      ($signed(val_r) < $signed(push_meta.tail));

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    live_nxt      = live_r;
    sel_nxt       = sel_r;
    val_nxt       = val_r;
    iss_nxt       = iss_r;
    s1_v_nxt      = 1'b0;
    s1_idx_nxt    = s1_idx_r;
    s2_v_nxt      = 1'b0;
    s2_idx_nxt    = s2_idx_r;
    s2_meta_nxt   = s2_meta_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_val_nxt  = best_val_r;
    best_meta_nxt = best_meta_r;
    res_val_nxt   = res_val_r;
    res_src_nxt   = res_src_r;
    res_st_nxt    = res_st_r;
    meta_we       = 1'b0;
    meta_waddr    = sel_r;
    meta_wdata    = '0;
    meta_raddr    = in_sel;
    store_we      = 1'b0;
    store_waddr   = {sel_r, push_pos};
    store_wdata   = val_r;
    store_raddr   = {s1_idx_r, scan_meta.rp};

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          sel_nxt     = in_sel;
          val_nxt     = in_val;
          res_val_nxt = '0;
          res_src_nxt = '0;
          res_st_nxt  = ST_OK;
          unique case (in_cmd)
            CMD_PUSH: begin
              if (CFG_W'(in_sel) >= n_act) begin
                res_st_nxt = ST_BAD;
                state_nxt  = S_DONE;
              end else begin
                meta_raddr = in_sel;
                state_nxt  = S_PUSH;
              end
            end
            CMD_POP: begin
              meta_raddr = '0;
              iss_nxt    = CFG_W'(1);
              s1_v_nxt   = 1'b1;
              s1_idx_nxt = '0;
              found_nxt  = 1'b0;
              state_nxt  = S_SCAN;
            end
            CMD_CLEAR: begin
              live_nxt  = '0;
              state_nxt = S_DONE;
            end
            default: begin
              res_st_nxt = ST_BAD;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end

      S_PUSH: begin
        // metadata of sel_r is on the read port now
        if (push_full) begin
          res_st_nxt = ST_FULL;
        end else if (push_order) begin
          res_st_nxt = ST_ORDER;
        end else begin
          store_we         = 1'b1;
          meta_we          = 1'b1;
          meta_wdata.rp    = push_meta.rp;
          meta_wdata.cnt   = push_meta.cnt + CNT_W'(1);
          meta_wdata.tail  = val_r;
          live_nxt[sel_r]  = 1'b1;
        end
        state_nxt = S_DONE;
      end

      S_SCAN: begin
        if (iss_r < n_act) begin
          meta_raddr = iss_r[SEL_W-1:0];
          iss_nxt    = iss_r + CFG_W'(1);
          s1_v_nxt   = 1'b1;
          s1_idx_nxt = iss_r[SEL_W-1:0];
        end
        if (s1_v_r) begin
          s2_v_nxt    = (scan_meta.cnt != '0);
          s2_idx_nxt  = s1_idx_r;
          s2_meta_nxt = scan_meta;
        end
        // <= : the later (higher) list wins a tie
        if (s2_v_r && (!found_r || ($signed(store_rdata) <= best_val_r))) begin
          found_nxt     = 1'b1;
          best_idx_nxt  = s2_idx_r;
          best_val_nxt  = $signed(store_rdata);
          best_meta_nxt = s2_meta_r;
        end
        if ((iss_r >= n_act) && !s1_v_r && !s2_v_r) begin
          if (!found_r) begin
            res_st_nxt = ST_EMPTY;
          end else begin
            meta_we         = 1'b1;
            meta_waddr      = best_idx_r;
            meta_wdata.rp   = rp_inc;
            meta_wdata.cnt  = best_meta_r.cnt - CNT_W'(1);
            meta_wdata.tail = best_meta_r.tail;
            res_val_nxt     = best_val_r;
            res_src_nxt     = best_idx_r;
            res_st_nxt      = ST_OK;
          end
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= CFG_W'(NUM_LISTS);
      live_r      <= '0;
      iss_r       <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        cfg_r <= cfg_data;
      end
      live_r  <= live_nxt;
      iss_r   <= iss_nxt;
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      found_r <= found_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    sel_r       <= sel_nxt;
    val_r       <= val_nxt;
    s1_idx_r    <= s1_idx_nxt;
    s2_idx_r    <= s2_idx_nxt;
    s2_meta_r   <= s2_meta_nxt;
    best_idx_r  <= best_idx_nxt;
    best_val_r  <= best_val_nxt;
    best_meta_r <= best_meta_nxt;
    res_val_r   <= res_val_nxt;
    res_src_r   <= res_src_nxt;
    res_st_r    <= res_st_nxt;
    if (out_load) begin
      out_val_r <= res_val_r;
      out_src_r <= res_src_r;
      out_st_r  <= res_st_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_src_r, out_val_r});
  assign out_tuser  = out_st_r;

  // read pointer, fill count and tail of every list
  kwm_ram #(
    .WIDTH (META_W),
    .DEPTH (NUM_LISTS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  // element values, list index in the upper address bits
  kwm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (store_wdata),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

`ifndef SYNTHESIS
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_cmd == CMD_CLEAR)) |=> (live_r == '0))
    else $error("clear left a list live");

  a_meta_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    meta_we |-> ((state_r == S_PUSH) || (state_r == S_SCAN)))
    else $error("metadata write outside push or scan");

  a_store_wr_full: assert property (@(posedge clk) disable iff (!rst_n)
    store_we |-> ((state_r == S_PUSH) && (push_meta.cnt != CNT_W'(LIST_DEPTH))))
    else $error("element write into a full list");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (iss_r <= n_act))
    else $error("scan ran past the lists in use");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r || s2_v_r) |-> (state_r == S_SCAN))
    else $error("scan pipeline busy outside scan");
`endif

endmodule

`default_nettype wire
